// File: hw/rtl/quoted_line_splitter_core_assert.svh
// Assertion macros used by the splitter checker.
`ifndef QUOTED_LINE_SPLITTER_CORE_ASSERT_SVH
`define QUOTED_LINE_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qls check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define QLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qls check failed: next-cycle rule");

`endif

// File: hw/rtl/qls_pkg.sv
// Shared types and constants of the quoted line splitter.
package qls_pkg;

  localparam int MAX_LINE = 4096;
  localparam int CW       = 12;  // width of line counters and positions
  localparam int BW       = 8;   // byte width

  localparam logic [CW-1:0] LIMIT_RESET = CW'(MAX_LINE - 1);
  localparam logic [CW-1:0] LIMIT_MIN   = CW'(1);

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_CHAR_LIMIT = 1'b0;  // register index, paddr[2]

  // Byte codes the front end reacts to
  localparam logic [BW-1:0] CH_NUL    = 8'h00;
  localparam logic [BW-1:0] CH_TAB    = 8'h09;
  localparam logic [BW-1:0] CH_LF     = 8'h0A;
  localparam logic [BW-1:0] CH_CR     = 8'h0D;
  localparam logic [BW-1:0] CH_SPACE  = 8'h20;
  localparam logic [BW-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BW-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BW-1:0] CH_BSLASH = 8'h5C;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // One classified item: an optional kept character, then an optional line end.
  typedef struct packed {
    logic          has_char;
    logic [BW-1:0] ch;
    logic [CW-1:0] pos;
    logic          has_end;
    logic [CW-1:0] len;
  } qls_op_t;

endpackage

// File: hw/rtl/qls_front.sv
// Front end: classify each byte, track line state, emit one op per item.
module qls_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [qls_pkg::BW-1:0]      text_byte,
  input  logic                        end_of_input,
  input  logic [qls_pkg::CW-1:0]      char_limit,
  output logic                        op_valid,
  output qls_pkg::qls_op_t            op
);

  logic [qls_pkg::CW-1:0] kept_r, kept_nxt;
  logic [qls_pkg::CW-1:0] len_r, len_nxt;
  logic                   quote_r, quote_nxt;
  logic                   esc_r, esc_nxt;

  logic                   keep, brk, cut, blank;
  logic [qls_pkg::CW-1:0] kept_inc, len_inc, lim;

  assign lim      = (char_limit == '0) ? qls_pkg::LIMIT_MIN : char_limit;
  assign kept_inc = kept_r + qls_pkg::CW'(1);
  assign blank    = text_byte inside {qls_pkg::CH_SPACE, qls_pkg::CH_TAB};
  assign len_inc  = blank ? len_r : kept_inc;
  assign cut      = (kept_inc >= lim);

  always_comb begin
    keep      = 1'b0;
    brk       = 1'b0;
    esc_nxt   = esc_r;
    quote_nxt = quote_r;
    kept_nxt  = kept_r;
    len_nxt   = len_r;
    op        = '0;

    if (end_of_input) begin
      brk       = (kept_r != '0);
      kept_nxt  = '0;
      len_nxt   = '0;
      quote_nxt = 1'b0;
      esc_nxt   = 1'b0;
    end else begin
      case (text_byte)
        qls_pkg::CH_NUL, qls_pkg::CH_CR: begin
          keep = 1'b0;
        end
        qls_pkg::CH_SEMI: begin
          if (esc_r || quote_r) keep = 1'b1;
          else brk = (kept_r != '0);
        end
        qls_pkg::CH_LF: begin
          brk = (kept_r != '0);
        end
        qls_pkg::CH_BSLASH: begin
          if (esc_r) keep = 1'b1;
          else esc_nxt = 1'b1;
        end
        qls_pkg::CH_QUOTE: begin
          if (esc_r) keep = 1'b1;
          else quote_nxt = ~quote_r;
        end
        qls_pkg::CH_SPACE, qls_pkg::CH_TAB: begin
          keep = (kept_r != '0);
        end
        default: begin
          keep = 1'b1;
        end
      endcase
    end

    if (keep) begin
      op.has_char = 1'b1;
      op.ch       = text_byte;
      op.pos      = kept_r;
      esc_nxt     = 1'b0;
      kept_nxt    = kept_inc;
      len_nxt     = len_inc;
      if (cut) begin
        op.has_end = 1'b1;
        op.len     = len_inc;
      end
    end

    if (brk) begin
      op.has_end = 1'b1;
      op.len     = len_r;
    end

    // any line end clears the line state
    if (op.has_end) begin
      kept_nxt  = '0;
      len_nxt   = '0;
      quote_nxt = 1'b0;
      esc_nxt   = 1'b0;
    end
  end

  assign op_valid = accept && (keep || brk);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r  <= '0;
      len_r   <= '0;
      quote_r <= 1'b0;
      esc_r   <= 1'b0;
    end else if (accept) begin
      kept_r  <= kept_nxt;
      len_r   <= len_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule

// File: hw/rtl/qls_queue.sv
// Short op queue that decouples the front end from the result side.
module qls_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  qls_pkg::qls_op_t        wr_op,
  input  logic                    rd_en,
  output qls_pkg::qls_op_t        rd_op,
  output logic                    q_empty,
  output logic                    q_full
);

  qls_pkg::qls_op_t             mem_r [qls_pkg::QDEPTH];
  logic [qls_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [qls_pkg::QCW-1:0]      cnt_r, cnt_nxt;
  logic                         do_wr, do_rd;

  assign q_empty = (cnt_r == '0);
  assign q_full  = (cnt_r == qls_pkg::QCW'(qls_pkg::QDEPTH));
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_op   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + qls_pkg::QCW'(1);
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - qls_pkg::QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + qls_pkg::QAW'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + qls_pkg::QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/qls_back.sv
// Back end: expand each queued op into one or two result items.
module qls_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qls_pkg::qls_op_t        head,
  input  logic                    head_valid,
  input  logic                    res_pop,
  output logic                    head_done,
  output logic                    res_kind,
  output logic [qls_pkg::BW-1:0]  res_char,
  output logic [qls_pkg::CW-1:0]  res_pos,
  output logic [qls_pkg::CW-1:0]  res_len,
  output logic                    res_last
);

  logic phase_r, phase_nxt;  // set once the character of a split op is gone
  logic show_char, taken;

  assign show_char = head.has_char && !phase_r;
  assign taken     = res_pop && head_valid;

  always_comb begin
    if (show_char) begin
      res_kind = qls_pkg::KIND_CHAR;
      res_char = head.ch;
      res_pos  = head.pos;
      res_len  = '0;
      res_last = !head.has_end;
    end else begin
      res_kind = qls_pkg::KIND_EOL;
      res_char = '0;
      res_pos  = '0;
      res_len  = head.len;
      res_last = 1'b1;
    end
  end

  assign head_done = taken && res_last;

  always_comb begin
    phase_nxt = phase_r;
    if (head_done) phase_nxt = 1'b0;
    else if (taken) phase_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= 1'b0;
    else phase_r <= phase_nxt;
  end

endmodule

// File: hw/rtl/quoted_line_splitter_core.sv
// Quoted line splitter: byte stream in, kept characters and line ends out.
// A result reaches the out_ ports from the op queue entry that its byte wrote.
// Throughput: one byte per cycle while the op queue has room; a byte that cuts a line gives two
//   results, which the result side hands out in turn while the 4-entry op queue absorbs input.
// Reset (rst_n low, synchronous): line state, queue and result phase clear,
//   char_limit returns to 4095.
module quoted_line_splitter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input, queue-style
  input  logic                          push,
  output logic                          full,
  input  logic [qls_pkg::BW-1:0]        in_text_byte,
  input  logic                          in_end_of_input,
  // results, queue-style
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_kind,
  output logic [qls_pkg::BW-1:0]        out_char_out,
  output logic [qls_pkg::CW-1:0]        out_position,
  output logic [qls_pkg::CW-1:0]        out_line_length,
  output logic                          out_last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qls_pkg::APB_AW-1:0]    paddr,
  input  logic [qls_pkg::APB_DW-1:0]    pwdata,
  output logic [qls_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  // Configuration register: the line cut length. Register 0 sits at byte
  // address 0; paddr[2] carries the register index, so address 4 reads zero
  // and ignores writes.
  logic [qls_pkg::CW-1:0] char_limit_r, char_limit_nxt;
  logic                   cfg_wr, cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == qls_pkg::REG_CHAR_LIMIT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? qls_pkg::APB_DW'(char_limit_r) : '0;

  always_comb begin
    char_limit_nxt = char_limit_r;
    if (cfg_wr) char_limit_nxt = pwdata[qls_pkg::CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) char_limit_r <= qls_pkg::LIMIT_RESET;
    else char_limit_r <= char_limit_nxt;
  end

  // Front end: accept whenever the op queue has room. Every accepted byte
  // updates the line state; only bytes that produce results enqueue an op.
  logic             accept, op_valid, q_full, q_empty, head_done;
  qls_pkg::qls_op_t op, head;

  assign full   = q_full;
  assign accept = push && !q_full;

  qls_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .text_byte    (in_text_byte),
    .end_of_input (in_end_of_input),
    .char_limit   (char_limit_r),
    .op_valid     (op_valid),
    .op           (op)
  );

  // Op queue: hold classified work until the result side drains it.
  qls_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (op_valid),
    .wr_op   (op),
    .rd_en   (head_done),
    .rd_op   (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // Back end: show the head op as a character, then as a line end when it
  // carries both; advance the queue only after its final item is popped.
  assign empty = q_empty;

  qls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .res_pop    (pop),
    .head_done  (head_done),
    .res_kind   (out_kind),
    .res_char   (out_char_out),
    .res_pos    (out_position),
    .res_len    (out_line_length),
    .res_last   (out_last)
  );

endmodule

// File: hw/rtl/qls_checker.sv
// Port-level checker for the quoted line splitter, bound to the top level.
`include "quoted_line_splitter_core_assert.svh"

module qls_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     empty,
  input logic                     pop,
  input logic                     out_kind,
  input logic [qls_pkg::BW-1:0]   out_char_out,
  input logic [qls_pkg::CW-1:0]   out_position,
  input logic [qls_pkg::CW-1:0]   out_line_length,
  input logic                     out_last
);

  `QLS_ASSERT_NOW(a_eol_fields, !empty && out_kind, out_char_out == '0 && out_position == '0 && out_last)
  `QLS_ASSERT_NOW(a_char_fields, !empty && !out_kind, out_line_length == '0)
  `QLS_ASSERT_NEXT(a_cut_follows, !empty && !out_kind && !out_last && pop, !empty && out_kind)
  `QLS_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(out_kind) && $stable(out_char_out) && $stable(out_position))

endmodule

bind quoted_line_splitter_core qls_checker u_qls_checker (.*);
